// File: rtl/greedy_iou_box_suppression_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the box suppression core
// Clocked concurrent assertions with the core's clock and reset.
// ----------------------------------------------------------------------------
`ifndef GREEDY_IOU_BOX_SUPPRESSION_CORE_MACROS_SVH
`define GREEDY_IOU_BOX_SUPPRESSION_CORE_MACROS_SVH

// Property holds at every clock edge outside reset
`define GIBS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next
`define GIBS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/gibs_pkg.sv
// ----------------------------------------------------------------------------
// gibs_pkg
// Types, widths and helpers shared by the box suppression core.
// ----------------------------------------------------------------------------
`default_nettype none

package gibs_pkg;

  localparam int MAX_BOXES  = 64;
  localparam int ADDR_W     = $clog2(MAX_BOXES);
  localparam int CNT_W      = $clog2(MAX_BOXES + 1);
  localparam int COORD_BITS = 14;
  localparam int SCORE_W    = 16;
  localparam int CLASS_W    = 8;
  localparam int THR_W      = 16;
  localparam int EXT_W      = COORD_BITS + 1;
  localparam int AREA_W     = 2 * EXT_W;
  localparam int UNI_W      = AREA_W + 1;
  localparam int MUL_A_W    = (THR_W > EXT_W) ? THR_W : EXT_W;
  localparam int PROD_W     = MUL_A_W + UNI_W;
  localparam logic [THR_W-1:0]      THR_RESET = THR_W'(29491);
  localparam logic [COORD_BITS-1:0] ONE_PIXEL = COORD_BITS'(16);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x_min;
    coord_t y_min;
    coord_t x_max;
    coord_t y_max;
  } corners_t;

  typedef struct packed {
    corners_t             corners;
    logic [SCORE_W-1:0]   score;
    logic [CLASS_W-1:0]   class_id;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  typedef struct packed {
    logic                box_present;
    coord_t              x_min;
    coord_t              y_min;
    coord_t              x_max;
    coord_t              y_max;
    logic [SCORE_W-1:0]  score;
    logic [CLASS_W-1:0]  class_id;
    logic                frame_end;
  } in_req_t;

  typedef struct packed {
    logic                empty_frame;
    coord_t              out_x_min;
    coord_t              out_y_min;
    coord_t              out_x_max;
    coord_t              out_y_max;
    logic [SCORE_W-1:0]  out_score;
    logic [CLASS_W-1:0]  out_class_id;
    logic                overflowed;
    logic                last_result;
  } out_req_t;

  // Extent from lo to hi plus one pixel, floored at zero
  function automatic logic [EXT_W-1:0] f_ext(input coord_t lo, input coord_t hi);
    logic [EXT_W-1:0] top;
    top = {1'b0, hi} + {1'b0, ONE_PIXEL};
    return (top > {1'b0, lo}) ? top - {1'b0, lo} : '0;
  endfunction

  function automatic coord_t f_max(input coord_t a, input coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic coord_t f_min(input coord_t a, input coord_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/gibs_in_if.sv
// ----------------------------------------------------------------------------
// gibs_in_if
// Valid/ready channel carrying one box request.
// ----------------------------------------------------------------------------
`default_nettype none

interface gibs_in_if;
  import gibs_pkg::*;
  logic    valid;
  logic    ready;
  in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/gibs_out_if.sv
// ----------------------------------------------------------------------------
// gibs_out_if
// Valid/ready channel carrying one kept-box result.
// ----------------------------------------------------------------------------
`default_nettype none

interface gibs_out_if;
  import gibs_pkg::*;
  logic     valid;
  logic     ready;
  out_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/gibs_ram.sv
// ----------------------------------------------------------------------------
// gibs_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gibs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/greedy_iou_box_suppression_core.sv
// ----------------------------------------------------------------------------
// Greedy IoU box suppression core
// in_ch takes one box request per handshake; frame_end closes a frame.
// Boxes load at one per cycle into the 64-entry arrival stores; extra boxes
// are dropped and every result of that frame carries overflowed. cfg_we and
// cfg_wdata set the IoU threshold (Q0.16); the user must write it only
// between frames, as the core does not enforce this. After frame_end the
// core ranks the boxes by descending score (stable) into the score-ordered
// stores. Suppression then clears the keep bit of each lower-ranked kept
// box whose IoU with a higher-ranked kept box reaches the threshold; the
// output scan then sends the kept boxes in score order. The core has one
// shared multiplier, and each box store has a single read port. An empty
// frame yields one empty_frame result. in_ch is not ready from frame_end
// until the output scan ends. A stalled receiver holds the output register
// and pauses the sequencer. Reset (synchronous, rst_n low) empties the frame
// and loads the default threshold; the box stores need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "greedy_iou_box_suppression_core_macros.svh"

module greedy_iou_box_suppression_core
  import gibs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  gibs_in_if.sink               in_ch,
  gibs_out_if.source            out_ch,
  input  wire logic             cfg_we,
  input  wire logic [THR_W-1:0] cfg_wdata
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_R_RDI = 5'd1;
  localparam logic [4:0] S_R_LDI = 5'd2;
  localparam logic [4:0] S_R_RDJ = 5'd3;
  localparam logic [4:0] S_R_CMP = 5'd4;
  localparam logic [4:0] S_R_WR  = 5'd5;
  localparam logic [4:0] S_S_BEG = 5'd6;
  localparam logic [4:0] S_S_RDA = 5'd7;
  localparam logic [4:0] S_S_LDA = 5'd8;
  localparam logic [4:0] S_S_RDB = 5'd9;
  localparam logic [4:0] S_S_AB  = 5'd10;
  localparam logic [4:0] S_S_IN  = 5'd11;
  localparam logic [4:0] S_S_UN  = 5'd12;
  localparam logic [4:0] S_S_CMP = 5'd13;
  localparam logic [4:0] S_O_SCN = 5'd14;
  localparam logic [4:0] S_O_RD  = 5'd15;
  localparam logic [4:0] S_E_OUT = 5'd16;

  function automatic logic [MAX_BOXES-1:0] below_mask(input logic [CNT_W-1:0] n);
    logic [MAX_BOXES-1:0] m;
    for (int k = 0; k < MAX_BOXES; k++) begin
      m[k] = (CNT_W'(k) < n);
    end
    return m;
  endfunction

  logic [4:0]            state_r, state_nxt;
  logic [THR_W-1:0]      thr_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [MAX_BOXES-1:0]  keep_r, keep_nxt;
  logic [CNT_W-1:0]      i_r, i_nxt;
  logic [CNT_W-1:0]      j_r, j_nxt;
  logic [ADDR_W-1:0]     rank_r, rank_nxt;
  box_t                  boxi_r;
  corners_t              ca_r;
  logic [AREA_W-1:0]     area_a_r, area_b_r, inter_r;
  logic [EXT_W-1:0]      iw_r, ih_r;
  logic [UNI_W-1:0]      uni_r;
  logic                  out_valid_r, out_valid_nxt;
  out_req_t              out_data_r, out_data_nxt;

  logic                  in_acc;
  logic                  u_we, s_we;
  box_t                  u0_rd, u1_rd, s0_rd, s1_rd;
  logic [MUL_A_W-1:0]    mul_a;
  logic [UNI_W-1:0]      mul_b;
  logic [PROD_W-1:0]     mul_p;
  logic [PROD_W-1:0]     lhs;
  logic                  out_free;
  logic                  out_load;
  logic                  out_empty;
  logic [ADDR_W-1:0]     i_idx, j_idx;
  logic [MAX_BOXES-1:0]  later_mask;
  logic                  rank_before;

  assign i_idx  = i_r[ADDR_W-1:0];
  assign j_idx  = j_r[ADDR_W-1:0];
  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign out_free = !out_valid_r || out_ch.ready;

  // Arrival-order stores, one per read address stream
  assign u_we = in_acc && in_ch.data.box_present && (cnt_r < CNT_W'(MAX_BOXES));

  gibs_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_store0 (
    .clk(clk), .we(u_we), .waddr(cnt_r[ADDR_W-1:0]),
    .wdata({in_ch.data.x_min, in_ch.data.y_min, in_ch.data.x_max,
            in_ch.data.y_max, in_ch.data.score, in_ch.data.class_id}),
    .raddr(i_idx), .rdata(u0_rd)
  );

  gibs_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_store1 (
    .clk(clk), .we(u_we), .waddr(cnt_r[ADDR_W-1:0]),
    .wdata({in_ch.data.x_min, in_ch.data.y_min, in_ch.data.x_max,
            in_ch.data.y_max, in_ch.data.score, in_ch.data.class_id}),
    .raddr(j_idx), .rdata(u1_rd)
  );

  // Score-ordered stores, written at each box's rank
  assign s_we = (state_r == S_R_WR);

  gibs_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_sorted0 (
    .clk(clk), .we(s_we), .waddr(rank_r), .wdata(boxi_r),
    .raddr(i_idx), .rdata(s0_rd)
  );

  gibs_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_sorted1 (
    .clk(clk), .we(s_we), .waddr(rank_r), .wdata(boxi_r),
    .raddr(j_idx), .rdata(s1_rd)
  );

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_S_LDA: begin
        mul_a = MUL_A_W'(f_ext(s0_rd.corners.x_min, s0_rd.corners.x_max));
        mul_b = UNI_W'(f_ext(s0_rd.corners.y_min, s0_rd.corners.y_max));
      end
      S_S_AB: begin
        mul_a = MUL_A_W'(f_ext(s1_rd.corners.x_min, s1_rd.corners.x_max));
        mul_b = UNI_W'(f_ext(s1_rd.corners.y_min, s1_rd.corners.y_max));
      end
      S_S_IN: begin
        mul_a = MUL_A_W'(iw_r);
        mul_b = UNI_W'(ih_r);
      end
      S_S_CMP: begin
        mul_a = MUL_A_W'(thr_r);
        mul_b = uni_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign lhs   = {{(PROD_W - AREA_W - THR_W){1'b0}}, inter_r, {THR_W{1'b0}}};

  // Stable descending order: earlier equal scores rank ahead
  assign rank_before = (u1_rd.score > boxi_r.score) ||
                       ((u1_rd.score == boxi_r.score) && (j_r < i_r));

  assign later_mask = keep_r & ~((MAX_BOXES'(2) << i_idx) - MAX_BOXES'(1));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    keep_nxt      = keep_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rank_nxt      = rank_r;
    out_load      = 1'b0;
    out_empty     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.data.box_present) begin
            if (cnt_r < CNT_W'(MAX_BOXES)) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (in_ch.data.frame_end) begin
            i_nxt = '0;
            state_nxt = (cnt_nxt == '0) ? S_E_OUT : S_R_RDI;
          end
        end
      end
      S_R_RDI: state_nxt = S_R_LDI;
      S_R_LDI: begin
        j_nxt     = '0;
        rank_nxt  = '0;
        state_nxt = S_R_RDJ;
      end
      S_R_RDJ: state_nxt = S_R_CMP;
      S_R_CMP: begin
        if (rank_before) begin
          rank_nxt = rank_r + ADDR_W'(1);
        end
        j_nxt = j_r + CNT_W'(1);
        state_nxt = (j_r + CNT_W'(1) == cnt_r) ? S_R_WR : S_R_RDJ;
      end
      S_R_WR: begin
        i_nxt = i_r + CNT_W'(1);
        state_nxt = (i_r + CNT_W'(1) == cnt_r) ? S_S_BEG : S_R_RDI;
      end
      S_S_BEG: begin
        keep_nxt  = below_mask(cnt_r);
        i_nxt     = '0;
        state_nxt = S_S_RDA;
      end
      S_S_RDA: begin
        if (i_r == cnt_r) begin
          i_nxt     = '0;
          state_nxt = S_O_SCN;
        end else if (!keep_r[i_idx]) begin
          i_nxt = i_r + CNT_W'(1);
        end else begin
          state_nxt = S_S_LDA;
        end
      end
      S_S_LDA: begin
        j_nxt     = i_r + CNT_W'(1);
        state_nxt = S_S_RDB;
      end
      S_S_RDB: begin
        if (j_r == cnt_r) begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_S_RDA;
        end else if (!keep_r[j_idx]) begin
          j_nxt = j_r + CNT_W'(1);
        end else begin
          state_nxt = S_S_AB;
        end
      end
      S_S_AB:  state_nxt = S_S_IN;
      S_S_IN:  state_nxt = S_S_UN;
      S_S_UN:  state_nxt = S_S_CMP;
      S_S_CMP: begin
        if ((uni_r != '0) && (lhs >= mul_p)) begin
          keep_nxt[j_idx] = 1'b0;
        end
        j_nxt     = j_r + CNT_W'(1);
        state_nxt = S_S_RDB;
      end
      S_O_SCN: begin
        if (i_r == cnt_r) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          keep_nxt  = '0;
          state_nxt = S_IDLE;
        end else if (keep_r[i_idx]) begin
          state_nxt = S_O_RD;
        end else begin
          i_nxt = i_r + CNT_W'(1);
        end
      end
      S_O_RD: begin
        if (out_free) begin
          out_load  = 1'b1;
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_O_SCN;
        end
      end
      S_E_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_empty = 1'b1;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          keep_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ch.ready);

  // Build the next result: a kept box, or the empty-frame marker
  always_comb begin
    out_data_nxt = '0;
    if (out_empty) begin
      out_data_nxt.empty_frame = 1'b1;
      out_data_nxt.last_result = 1'b1;
    end else begin
      out_data_nxt.out_x_min    = s0_rd.corners.x_min;
      out_data_nxt.out_y_min    = s0_rd.corners.y_min;
      out_data_nxt.out_x_max    = s0_rd.corners.x_max;
      out_data_nxt.out_y_max    = s0_rd.corners.y_max;
      out_data_nxt.out_score    = s0_rd.score;
      out_data_nxt.out_class_id = s0_rd.class_id;
      out_data_nxt.last_result  = (later_mask == '0);
    end
    out_data_nxt.overflowed = ovf_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= THR_RESET;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      keep_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      keep_r      <= keep_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      rank_r      <= rank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_R_LDI) begin
      boxi_r <= u0_rd;
    end
    if (state_r == S_S_LDA) begin
      ca_r     <= s0_rd.corners;
      area_a_r <= mul_p[AREA_W-1:0];
    end
    if (state_r == S_S_AB) begin
      area_b_r <= mul_p[AREA_W-1:0];
      iw_r <= f_ext(f_max(ca_r.x_min, s1_rd.corners.x_min),
                    f_min(ca_r.x_max, s1_rd.corners.x_max));
      ih_r <= f_ext(f_max(ca_r.y_min, s1_rd.corners.y_min),
                    f_min(ca_r.y_max, s1_rd.corners.y_max));
    end
    if (state_r == S_S_IN) begin
      inter_r <= mul_p[AREA_W-1:0];
    end
    if (state_r == S_S_UN) begin
      uni_r <= UNI_W'(area_a_r) + UNI_W'(area_b_r) - UNI_W'(inter_r);
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks
  `GIBS_ASSERT(a_cnt_range, cnt_r <= CNT_W'(MAX_BOXES), "box count beyond capacity")
  `GIBS_ASSERT(a_keep_in_frame, (keep_r & ~below_mask(cnt_r)) == '0, "keep bit past box count")
  `GIBS_ASSERT(a_pair_order, (state_r == S_S_AB) |-> (j_r > i_r), "pair test not below outer box")
  `GIBS_ASSERT(a_rank_range, (state_r == S_R_WR) |-> (CNT_W'(rank_r) < cnt_r), "rank out of range")
  `GIBS_ASSERT_NEXT(a_cmp_return, state_r == S_S_CMP, state_r == S_S_RDB, "pair test did not return")

endmodule

`default_nettype wire
